>>> design/dpg_pkg.sv
// Shared types, widths and codes for the detector event pile-up grader.
// No dependencies; imported by every module of the block.
package dpg_pkg;

  localparam int EVT_TIME_W     = 40;
  localparam int PIX_W          = 5;
  localparam int ROW_W          = 32;
  localparam int WIN_W          = 32;
  localparam int GRADE_W        = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_NUM_PIXELS = 32;
  localparam int DEF_TIME_BITS  = 40;
  localparam int IN_DEPTH       = 2;
  localparam int OUT_DEPTH      = 4;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST = 1'd1;

  localparam logic [GRADE_W-1:0] GRADE_NOMINAL = 2'd0;
  localparam logic [GRADE_W-1:0] GRADE_SLOW    = 2'd1;
  localparam logic [GRADE_W-1:0] GRADE_FAST    = 2'd2;
  localparam logic [GRADE_W-1:0] GRADE_RESET   = 2'd3;

  typedef struct packed {
    logic                  cmd;
    logic [EVT_TIME_W-1:0] event_time;
    logic [PIX_W-1:0]      pixel;
    logic                  in_reset;
    logic [ROW_W-1:0]      row;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [GRADE_W-1:0] grade;
    logic               last;
  } result_t;

  // up to two result words written in one cycle; v1 implies v0
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } res_pair_t;

  typedef enum logic {
    BK_ISSUE,
    BK_EXEC
  } bk_state_t;

endpackage

>>> design/detector_event_pileup_grader.sv
// Detector event pile-up grader, top level.
// A taken word's pixel state is read into registers, then graded and written back;
// the back end takes no new word until the write-back of the last one is done.
// Input and result queues let push continue while earlier words are graded.
// Synchronous reset clears queues, pixel valid bits and both window registers.
module detector_event_pileup_grader import dpg_pkg::*; #(
  parameter int NUM_PIXELS = DEF_NUM_PIXELS,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  cmd,
  input  logic [EVT_TIME_W-1:0] event_time,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  in_reset,
  input  logic [ROW_W-1:0]      row,
  output logic                  empty,
  input  logic                  pop,
  output logic [ROW_W-1:0]      out_row,
  output logic [GRADE_W-1:0]    grade,
  output logic                  last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WIN_W-1:0]      cfg_data
);

  logic      item_valid;
  item_t     item;
  logic      take;
  logic      room2;
  res_pair_t res;
  result_t   head;

  dpg_front #(.NUM_PIXELS(NUM_PIXELS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .event_time(event_time), .pixel(pixel), .in_reset(in_reset), .row(row),
    .item_valid(item_valid), .item(item), .take(take)
  );

  dpg_back #(.NUM_PIXELS(NUM_PIXELS), .TIME_BITS(TIME_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item_valid(item_valid), .item(item), .take(take),
    .room2(room2), .res(res)
  );

  dpg_out u_out (
    .clk(clk), .rst(rst), .res(res), .room2(room2), .empty(empty),
    .pop(pop), .head(head)
  );

  assign out_row = head.row;
  assign grade   = head.grade;
  assign last    = head.last;

  a_take_spacing: assert property (@(posedge clk) disable iff (rst)
    take |=> !take)
    else $error("back end took two words in a row");

  a_res_after_take: assert property (@(posedge clk) disable iff (rst)
    res.v0 |-> $past(take))
    else $error("results written without a word in progress");

  a_res_pair: assert property (@(posedge clk) disable iff (rst)
    res.v1 |-> res.v0)
    else $error("second result word without a first");

  a_take_room: assert property (@(posedge clk) disable iff (rst)
    take |-> (room2 && item_valid))
    else $error("word taken without queue room or data");

endmodule

>>> design/dpg_front.sv
// Front end: input queue that accepts words and drops those for pixels out of range.
// Depends on dpg_pkg.
module dpg_front import dpg_pkg::*; #(
  parameter int NUM_PIXELS = DEF_NUM_PIXELS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  cmd,
  input  logic [EVT_TIME_W-1:0] event_time,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  in_reset,
  input  logic [ROW_W-1:0]      row,
  output logic                  item_valid,
  output item_t                 item,
  input  logic                  take
);

  localparam int PW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int CW = $clog2(IN_DEPTH + 1);

  item_t         q [IN_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          in_range;
  logic          do_push;

  assign in_range   = 32'(pixel) < 32'(NUM_PIXELS);
  assign full       = (count == CW'(IN_DEPTH));
  assign do_push    = push && !full && in_range;
  assign item_valid = (count != '0);
  assign item       = q[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= '{cmd: cmd, event_time: event_time, pixel: pixel,
                 in_reset: in_reset, row: row};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(IN_DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (take) begin
        rp <= (rp == PW'(IN_DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(take);
    end
  end

endmodule

>>> design/dpg_back.sv
// Back end: per-pixel state memory, gap grading and result generation.
// Per word: read pixel state, then grade and write back. Depends on dpg_pkg.
module dpg_back import dpg_pkg::*; #(
  parameter int NUM_PIXELS = DEF_NUM_PIXELS,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_W-1:0]     cfg_data,
  input  logic                 item_valid,
  input  item_t                item,
  output logic                 take,
  input  logic                 room2,
  output res_pair_t            res
);

  // pixel port is 5 bits, so no more than 32 slots are reachable
  localparam int DEPTH = (NUM_PIXELS < (1 << PIX_W)) ? NUM_PIXELS : (1 << PIX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [TIME_BITS-1:0] mem_time   [DEPTH];
  logic [ROW_W-1:0]     mem_row    [DEPTH];
  logic [GRADE_W-1:0]   mem_before [DEPTH];

  logic [TIME_BITS-1:0] rd_time;
  logic [ROW_W-1:0]     rd_row;
  logic [GRADE_W-1:0]   rd_before;
  item_t                cur;

  logic [DEPTH-1:0] last_valid;
  logic [DEPTH-1:0] pending_valid;
  logic [WIN_W-1:0] slow_window;
  logic [WIN_W-1:0] fast_window;

  bk_state_t state;
  bk_state_t state_next;

  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        addr;
  logic [63:0]          t_wide;
  logic [TIME_BITS-1:0] t_cur;
  logic [TIME_BITS-1:0] gap;
  logic [63:0]          gap64;
  logic [GRADE_W-1:0]   cls;
  logic [GRADE_W-1:0]   pend_grade;
  logic                 exec;
  logic                 is_event;
  logic                 pv_hit;
  logic                 rst_hit;

  assign rd_addr  = item.pixel[AW-1:0];
  assign addr     = cur.pixel[AW-1:0];
  assign exec     = (state == BK_EXEC);
  assign is_event = (cur.cmd == CMD_EVENT);

  // time is taken modulo 2^TIME_BITS
  assign t_wide = 64'(cur.event_time);
  assign t_cur  = t_wide[TIME_BITS-1:0];
  assign gap    = (t_cur >= rd_time) ? t_cur - rd_time : '0;
  assign gap64  = 64'(gap);

  always_comb begin
    if (!last_valid[addr]) begin
      cls = GRADE_NOMINAL;
    end else if (gap64 > 64'(slow_window)) begin
      cls = GRADE_NOMINAL;
    end else if (gap64 < 64'(fast_window)) begin
      cls = GRADE_FAST;
    end else begin
      cls = GRADE_SLOW;
    end
  end

  // flush releases the stored grade; a later event may raise it
  assign pend_grade = (!is_event || rd_before > cls) ? rd_before : cls;
  assign pv_hit     = exec && pending_valid[addr];
  assign rst_hit    = exec && is_event && cur.in_reset;

  always_comb begin
    res.v0       = pv_hit || rst_hit;
    res.v1       = pv_hit && rst_hit;
    res.r0.row   = pv_hit ? rd_row : cur.row;
    res.r0.grade = pv_hit ? pend_grade : GRADE_RESET;
    res.r0.last  = !(pv_hit && rst_hit);
    res.r1.row   = cur.row;
    res.r1.grade = GRADE_RESET;
    res.r1.last  = 1'b1;
  end

  always_comb begin
    state_next = state;
    take       = 1'b0;
    case (state)
      BK_ISSUE: begin
        if (item_valid && room2) begin
          take       = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_next = BK_ISSUE;
      end
      default: begin
        state_next = BK_ISSUE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_ISSUE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_window <= '0;
      fast_window <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOW: slow_window <= cfg_data;
        CFG_FAST: fast_window <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel state memory: registered read on take, write-back in the exec cycle
  always_ff @(posedge clk) begin
    if (take) begin
      cur       <= item;
      rd_time   <= mem_time[rd_addr];
      rd_row    <= mem_row[rd_addr];
      rd_before <= mem_before[rd_addr];
    end
    if (exec && is_event) begin
      mem_time[addr] <= t_cur;
      if (!cur.in_reset) begin
        mem_row[addr]    <= cur.row;
        mem_before[addr] <= cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid    <= '0;
      pending_valid <= '0;
    end else if (exec) begin
      if (is_event) begin
        last_valid[addr]    <= 1'b1;
        pending_valid[addr] <= !cur.in_reset;
      end else begin
        pending_valid[addr] <= 1'b0;
      end
    end
  end

endmodule

>>> design/dpg_out.sv
// Result queue: takes up to two words a cycle, hands out one a cycle.
// Depends on dpg_pkg.
module dpg_out import dpg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_pair_t res,
  output logic      room2,
  output logic      empty,
  input  logic      pop,
  output result_t   head
);

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  result_t       q [OUT_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign room2  = (count <= CW'(OUT_DEPTH - 2));
  assign head   = q[rp];

  always_ff @(posedge clk) begin
    if (res.v0) begin
      q[wp] <= res.r0;
    end
    if (res.v1) begin
      q[wp + PW'(1)] <= res.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(res.v0) + PW'(res.v1);
      rp    <= rp + PW'(do_pop);
      count <= count + CW'(res.v0) + CW'(res.v1) - CW'(do_pop);
    end
  end

endmodule

>>> dv/detector_event_pileup_grader_tb.sv
// Self-checking testbench for detector_event_pileup_grader: per-pixel gap grading,
// pending release on later event or flush, in-reset pass-through, window registers.
// Depends on design/dpg_pkg.sv and design/detector_event_pileup_grader.sv.
module detector_event_pileup_grader_tb import dpg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  push       = 1'b0;
  logic                  cmd        = CMD_EVENT;
  logic [EVT_TIME_W-1:0] event_time = '0;
  logic [PIX_W-1:0]      pixel      = '0;
  logic                  in_reset   = 1'b0;
  logic [ROW_W-1:0]      row        = '0;
  logic                  pop        = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_SLOW;
  logic [WIN_W-1:0]      cfg_data   = '0;
  logic                  full;
  logic                  empty;
  logic [ROW_W-1:0]      out_row;
  logic [GRADE_W-1:0]    grade;
  logic                  last;

  // grader state as the block should hold it
  logic [WIN_W-1:0]      slow_win;
  logic [WIN_W-1:0]      fast_win;
  logic [EVT_TIME_W-1:0] prev_time  [DEF_NUM_PIXELS];
  bit                    prev_seen  [DEF_NUM_PIXELS];
  bit                    held       [DEF_NUM_PIXELS];
  logic [ROW_W-1:0]      held_row   [DEF_NUM_PIXELS];
  logic [GRADE_W-1:0]    held_grade [DEF_NUM_PIXELS];

  result_t               grades_due [$];
  logic [EVT_TIME_W-1:0] tick_now;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    errors = 0;
  int                    idle_cycles = 0;

  detector_event_pileup_grader i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .event_time (event_time),
    .pixel      (pixel),
    .in_reset   (in_reset),
    .row        (row),
    .empty      (empty),
    .pop        (pop),
    .out_row    (out_row),
    .grade      (grade),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic item_t word_of(logic c, logic [EVT_TIME_W-1:0] t, logic [PIX_W-1:0] p,
                                    logic rs, logic [ROW_W-1:0] r);
    item_t w;
    w.cmd = c;
    w.event_time = t;
    w.pixel = p;
    w.in_reset = rs;
    w.row = r;
    return w;
  endfunction

  function automatic logic [GRADE_W-1:0] gap_grade(logic [EVT_TIME_W-1:0] gap);
    if (gap > EVT_TIME_W'(slow_win)) return GRADE_NOMINAL;
    if (gap < EVT_TIME_W'(fast_win)) return GRADE_FAST;
    return GRADE_SLOW;
  endfunction

  function automatic void predict_grades(item_t w);
    int                    p;
    int                    n0;
    logic [EVT_TIME_W-1:0] gap;
    logic [GRADE_W-1:0]    cls;
    result_t               r;
    p = int'(w.pixel);
    n0 = grades_due.size();
    cls = GRADE_NOMINAL;
    if (w.cmd == CMD_FLUSH) begin
      if (held[p]) begin
        grades_due.push_back('{row: held_row[p], grade: held_grade[p], last: 1'b0});
        held[p] = 1'b0;
      end
    end else begin
      if (prev_seen[p]) begin
        // time running backwards counts as a zero gap
        gap = (w.event_time >= prev_time[p]) ? w.event_time - prev_time[p] : '0;
        cls = gap_grade(gap);
      end
      if (held[p]) begin
        grades_due.push_back('{row: held_row[p],
                               grade: (held_grade[p] > cls) ? held_grade[p] : cls,
                               last: 1'b0});
        held[p] = 1'b0;
      end
      if (w.in_reset) begin
        grades_due.push_back('{row: w.row, grade: GRADE_RESET, last: 1'b0});
      end else begin
        held[p] = 1'b1;
        held_row[p] = w.row;
        held_grade[p] = cls;
      end
      prev_time[p] = w.event_time;
      prev_seen[p] = 1'b1;
    end
    if (grades_due.size() > n0) begin
      r = grades_due.pop_back();
      r.last = 1'b1;
      grades_due.push_back(r);
    end
  endfunction

  // push stays high between back-to-back words; lowered only for a gap
  task automatic push_word(item_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    push       <= 1'b1;
    cmd        <= w.cmd;
    event_time <= w.event_time;
    pixel      <= w.pixel;
    in_reset   <= w.in_reset;
    row        <= w.row;
    do @(posedge clk); while (full);
    predict_grades(w);
  endtask

  // words that release nothing may still be in flight when the queue runs dry
  task automatic drain();
    push <= 1'b0;
    while (grades_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_windows(logic [WIN_W-1:0] slow, logic [WIN_W-1:0] fast);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLOW;
    cfg_data  <= slow;
    @(posedge clk);
    cfg_index <= CFG_FAST;
    cfg_data  <= fast;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slow_win = slow;
    fast_win = fast;
  endtask

  task automatic test_grading_basics();
    set_windows(32'd100, 32'd10);
    push_word(word_of(CMD_EVENT, 40'd1000, 5'd0, 1'b0, 32'h0000_0001));
    push_word(word_of(CMD_EVENT, 40'd1005, 5'd0, 1'b0, 32'h0000_0002));
    push_word(word_of(CMD_EVENT, 40'd1050, 5'd0, 1'b0, 32'h0000_0003));
    push_word(word_of(CMD_FLUSH, 40'hFF_FFFF_FFFF, 5'd0, 1'b1, 32'hFFFF_FFFF));
    // nothing left to flush
    push_word(word_of(CMD_FLUSH, 40'd0, 5'd0, 1'b0, 32'h0));
    push_word(word_of(CMD_EVENT, 40'd1200, 5'd0, 1'b0, 32'h0000_0004));
    push_word(word_of(CMD_EVENT, 40'd1201, 5'd0, 1'b1, 32'h0000_0005));
    push_word(word_of(CMD_EVENT, 40'd1300, 5'd0, 1'b0, 32'h0000_0006));
    // backwards in time
    push_word(word_of(CMD_EVENT, 40'd1250, 5'd0, 1'b0, 32'h0000_0007));
    // gap exactly at fast, at slow, one past slow
    push_word(word_of(CMD_EVENT, 40'd1260, 5'd0, 1'b0, 32'h0000_0008));
    push_word(word_of(CMD_EVENT, 40'd1360, 5'd0, 1'b0, 32'h0000_0009));
    push_word(word_of(CMD_EVENT, 40'd1461, 5'd0, 1'b0, 32'h0000_000A));
    // flush must not move the pixel's time
    push_word(word_of(CMD_FLUSH, 40'd9000, 5'd0, 1'b0, 32'h0));
    push_word(word_of(CMD_EVENT, 40'd1465, 5'd0, 1'b0, 32'h0000_000B));
    push_word(word_of(CMD_EVENT, 40'd1466, 5'd31, 1'b1, 32'hFFFF_FFFF));
    push_word(word_of(CMD_EVENT, 40'd1470, 5'd31, 1'b0, 32'h0000_0000));
    push_word(word_of(CMD_EVENT, 40'd1470, 5'd31, 1'b1, 32'h5A5A_A5A5));
    push_word(word_of(CMD_FLUSH, 40'd0, 5'd31, 1'b0, 32'h0));
    push_word(word_of(CMD_FLUSH, 40'd0, 5'd0, 1'b0, 32'h0));
    drain();
  endtask

  task automatic test_window_extremes();
    set_windows(32'd0, 32'd0);
    push_word(word_of(CMD_EVENT, 40'd500, 5'd7, 1'b0, 32'h0000_0100));
    push_word(word_of(CMD_EVENT, 40'd500, 5'd7, 1'b0, 32'h0000_0101));
    push_word(word_of(CMD_EVENT, 40'd501, 5'd7, 1'b0, 32'h0000_0102));
    push_word(word_of(CMD_FLUSH, 40'd0, 5'd7, 1'b0, 32'h0));
    drain();
    set_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(word_of(CMD_EVENT, 40'd0, 5'd8, 1'b0, 32'h0000_0200));
    push_word(word_of(CMD_EVENT, 40'h00_FFFF_FFFF, 5'd8, 1'b0, 32'h0000_0201));
    push_word(word_of(CMD_EVENT, 40'h01_FFFF_FFFD, 5'd8, 1'b0, 32'h0000_0202));
    push_word(word_of(CMD_EVENT, 40'hFF_FFFF_FFFF, 5'd8, 1'b0, 32'h0000_0203));
    push_word(word_of(CMD_FLUSH, 40'd0, 5'd8, 1'b0, 32'h0));
    drain();
    // fast above slow: a gap past slow is never a neighbor
    set_windows(32'd50, 32'd1000);
    push_word(word_of(CMD_EVENT, 40'd2000, 5'd9, 1'b0, 32'h0000_0300));
    push_word(word_of(CMD_EVENT, 40'd2030, 5'd9, 1'b0, 32'h0000_0301));
    push_word(word_of(CMD_EVENT, 40'd2100, 5'd9, 1'b0, 32'h0000_0302));
    push_word(word_of(CMD_EVENT, 40'd2150, 5'd9, 1'b1, 32'h0000_0303));
    push_word(word_of(CMD_FLUSH, 40'd0, 5'd9, 1'b0, 32'h0));
    drain();
  endtask

  task automatic test_random_traffic(int n);
    int                    sel;
    logic [PIX_W-1:0]      p;
    logic [EVT_TIME_W-1:0] step;
    for (int k = 0; k < n; k++) begin
      if (k % 150 == 0) begin
        drain();
        set_windows($urandom_range(400), $urandom_range(450));
      end
      sel = $urandom_range(99);
      // a few hot pixels so events find pending neighbors
      p = ($urandom_range(3) == 0) ? PIX_W'($urandom_range(31)) : PIX_W'($urandom_range(3));
      if (sel < 80) begin
        case ($urandom_range(7))
          0:       step = '0;
          1:       step = EVT_TIME_W'($urandom);
          default: step = EVT_TIME_W'($urandom_range((slow_win + fast_win) / 4 + 2));
        endcase
        tick_now = tick_now + step;
        push_word(word_of(CMD_EVENT, tick_now, p, ($urandom_range(9) == 0), $urandom));
      end else if (sel < 95) begin
        push_word(word_of(CMD_FLUSH, EVT_TIME_W'({$urandom, $urandom}), p,
                          1'($urandom_range(1)), $urandom));
      end else begin
        push_word(word_of(CMD_EVENT, tick_now - EVT_TIME_W'($urandom_range(400)), p,
                          ($urandom_range(9) == 0), $urandom));
      end
    end
    drain();
  endtask

  // result checker, receiver stalls and stall watchdog count
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (grades_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: row %h grade %0d last %0b", out_row, grade, last);
      end else begin
        want = grades_due.pop_front();
        if (out_row !== want.row || grade !== want.grade || last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: row exp %h got %h, grade exp %0d got %0d, last exp %0b got %0b",
                     want.row, out_row, want.grade, grade, want.last, last);
        end
      end
    end
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    slow_win = '0;
    fast_win = '0;
    for (int i = 0; i < DEF_NUM_PIXELS; i++) begin
      prev_time[i] = '0;
      prev_seen[i] = 1'b0;
      held[i] = 1'b0;
    end
    tick_now = {8'($urandom_range(127)), 32'($urandom)};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 54;
    test_grading_basics();
    test_window_extremes();
    test_random_traffic(560);

    send_idle_pct = 54;
    recv_idle_pct = 8;
    test_random_traffic(560);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(560);

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> detector_event_pileup_grader.f
design/dpg_pkg.sv
design/dpg_front.sv
design/dpg_back.sv
design/dpg_out.sv
design/detector_event_pileup_grader.sv
dv/detector_event_pileup_grader_tb.sv
